// ===== rtl/core/tacc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tacc_pkg
// Shared types, constants and helper functions of the temporal argmax color
// coder: frame limits, register map, configuration and stage-enable structs.
// ----------------------------------------------------------------------------
package tacc_pkg;

    localparam int MAX_FRAMES   = 8;
    localparam int NUM_SAMPLES  = 8;
    localparam int FRAME_CAP    = (MAX_FRAMES > NUM_SAMPLES) ? NUM_SAMPLES : MAX_FRAMES;
    localparam int FRAME_LIMIT  = (FRAME_CAP < 2) ? 2 : FRAME_CAP;
    localparam int FRAME_W      = $clog2(NUM_SAMPLES);
    localparam int COUNT_W      = 4;
    localparam int PIX_W        = 8;
    localparam int NUM_CHANNELS = 3;
    localparam int NUM_W        = PIX_W + FRAME_W;
    localparam int RECIP_SHIFT  = 14;
    localparam int RECIP_W      = RECIP_SHIFT + 1;
    localparam int PROD_W       = NUM_W + RECIP_W;

    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 32;

    localparam int STG_LANE   = 0;
    localparam int STG_LEVEL1 = 1;
    localparam int STG_LEVEL2 = 2;
    localparam int STG_LEVEL3 = 3;
    localparam int STG_NUM    = 4;
    localparam int STG_QUOT   = 5;
    localparam int STG_OUT    = 6;
    localparam int NUM_STAGES = 7;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef enum logic [IDX_W-1:0] {
        REG_FRAMES_IN_USE = 3'd0,
        REG_START_RED     = 3'd1,
        REG_START_GREEN   = 3'd2,
        REG_START_BLUE    = 3'd3,
        REG_END_RED       = 3'd4,
        REG_END_GREEN     = 3'd5,
        REG_END_BLUE      = 3'd6
    } reg_idx_t;

    localparam logic [COUNT_W-1:0] RST_FRAMES_IN_USE = 4'd8;
    localparam pixel_t RST_START_RED   = 8'd13;
    localparam pixel_t RST_START_GREEN = 8'd8;
    localparam pixel_t RST_START_BLUE  = 8'd135;
    localparam pixel_t RST_END_RED     = 8'd254;
    localparam pixel_t RST_END_GREEN   = 8'd243;
    localparam pixel_t RST_END_BLUE    = 8'd220;

    typedef struct packed {
        logic [COUNT_W-1:0]            frames_in_use;
        pixel_t [NUM_CHANNELS-1:0]     start_col;
        pixel_t [NUM_CHANNELS-1:0]     end_col;
    } cfg_t;

    typedef struct packed {
        logic level1;
        logic level2;
        logic level3;
    } merge_en_t;

    typedef struct packed {
        logic num;
        logic quot;
        logic scale;
    } blend_en_t;

    function automatic logic [COUNT_W-1:0] frame_count(input logic [COUNT_W-1:0] fiu);
        logic [COUNT_W-1:0] n;
        if (fiu < COUNT_W'(2)) begin
            n = COUNT_W'(2);
        end else if (fiu > COUNT_W'(FRAME_LIMIT)) begin
            n = COUNT_W'(FRAME_LIMIT);
        end else begin
            n = fiu;
        end
        return n;
    endfunction

    // ceil(2^14 / d): exact quotient for numerators below 2048 and d up to 7
    function automatic logic [RECIP_W-1:0] recip(input logic [FRAME_W-1:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            3'd1:    r = 15'd16384;
            3'd2:    r = 15'd8192;
            3'd3:    r = 15'd5462;
            3'd4:    r = 15'd4096;
            3'd5:    r = 15'd3277;
            3'd6:    r = 15'd2731;
            3'd7:    r = 15'd2341;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tacc_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tacc_lane
// One frame lane: registers its sample, forced to zero when the frame lies
// beyond the frames in use.
// ----------------------------------------------------------------------------
module tacc_lane
    import tacc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic [FRAME_W-1:0] lane_idx,
    input  wire logic [COUNT_W-1:0] frames,
    input  wire pixel_t             sample,
    output pixel_t                  lane_val_reg
);

    pixel_t lane_val_next;

    assign lane_val_next = (COUNT_W'(lane_idx) < frames) ? sample : '0;

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_val_reg <= lane_val_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/tacc_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tacc_merge
// Registered three-level compare tree over the lanes; keeps the largest
// sample and, on ties, the lower frame index.
// ----------------------------------------------------------------------------
module tacc_merge
    import tacc_pkg::*;
(
    input  wire logic                      aclk,
    input  wire merge_en_t                 en,
    input  wire pixel_t [NUM_SAMPLES-1:0]  lane_val,
    output pixel_t                         peak_reg,
    output logic [FRAME_W-1:0]             where_reg
);

    localparam int N1 = NUM_SAMPLES / 2;
    localparam int N2 = NUM_SAMPLES / 4;

    pixel_t [N1-1:0]             l1_val_reg, l1_val_next;
    logic   [N1-1:0][FRAME_W-1:0] l1_idx_reg, l1_idx_next;
    pixel_t [N2-1:0]             l2_val_reg, l2_val_next;
    logic   [N2-1:0][FRAME_W-1:0] l2_idx_reg, l2_idx_next;
    pixel_t                      peak_next;
    logic   [FRAME_W-1:0]        where_next;

    always_comb begin
        for (int j = 0; j < N1; j++) begin
            if (lane_val[2*j] >= lane_val[2*j+1]) begin
                l1_val_next[j] = lane_val[2*j];
                l1_idx_next[j] = FRAME_W'(2*j);
            end else begin
                l1_val_next[j] = lane_val[2*j+1];
                l1_idx_next[j] = FRAME_W'(2*j+1);
            end
        end
        for (int j = 0; j < N2; j++) begin
            if (l1_val_reg[2*j] >= l1_val_reg[2*j+1]) begin
                l2_val_next[j] = l1_val_reg[2*j];
                l2_idx_next[j] = l1_idx_reg[2*j];
            end else begin
                l2_val_next[j] = l1_val_reg[2*j+1];
                l2_idx_next[j] = l1_idx_reg[2*j+1];
            end
        end
        if (l2_val_reg[0] >= l2_val_reg[1]) begin
            peak_next  = l2_val_reg[0];
            where_next = l2_idx_reg[0];
        end else begin
            peak_next  = l2_val_reg[1];
            where_next = l2_idx_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.level1) begin
            l1_val_reg <= l1_val_next;
            l1_idx_reg <= l1_idx_next;
        end
        if (en.level2) begin
            l2_val_reg <= l2_val_next;
            l2_idx_reg <= l2_idx_next;
        end
        if (en.level3) begin
            peak_reg  <= peak_next;
            where_reg <= where_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/tacc_blend.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tacc_blend
// One color channel: interpolates between start and end color at the peak
// frame, divides by the frame span through a reciprocal, scales by the peak.
// ----------------------------------------------------------------------------
module tacc_blend
    import tacc_pkg::*;
(
    input  wire logic               aclk,
    input  wire blend_en_t          en,
    input  wire logic [FRAME_W-1:0] span,
    input  wire logic [FRAME_W-1:0] frame,
    input  wire pixel_t             start_val,
    input  wire pixel_t             end_val,
    input  wire pixel_t             peak,
    output pixel_t                  chan_reg
);

    logic [NUM_W-1:0]   num_reg, num_next;
    logic [FRAME_W-1:0] start_weight;
    logic [PROD_W-1:0]  quot_prod;
    pixel_t             color_reg, color_next;
    logic [2*PIX_W-1:0] scale_prod;

    assign start_weight = span - frame;
    assign num_next     = NUM_W'(start_val) * NUM_W'(start_weight)
                        + NUM_W'(end_val) * NUM_W'(frame)
                        + NUM_W'(span >> 1);

    assign quot_prod  = PROD_W'(num_reg) * PROD_W'(recip(span));
    assign color_next = quot_prod[RECIP_SHIFT +: PIX_W];

    assign scale_prod = (2*PIX_W)'(peak) * (2*PIX_W)'(color_reg);

    always_ff @(posedge aclk) begin
        if (en.num) begin
            num_reg <= num_next;
        end
        if (en.quot) begin
            color_reg <= color_next;
        end
        if (en.scale) begin
            chan_reg <= scale_prod[PIX_W +: PIX_W];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/tacc_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tacc_regs
// APB register file: frame count and start/end colors.
// ----------------------------------------------------------------------------
module tacc_regs
    import tacc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frames_in_use       <= RST_FRAMES_IN_USE;
            cfg_reg.start_col[CH_RED]   <= RST_START_RED;
            cfg_reg.start_col[CH_GREEN] <= RST_START_GREEN;
            cfg_reg.start_col[CH_BLUE]  <= RST_START_BLUE;
            cfg_reg.end_col[CH_RED]     <= RST_END_RED;
            cfg_reg.end_col[CH_GREEN]   <= RST_END_GREEN;
            cfg_reg.end_col[CH_BLUE]    <= RST_END_BLUE;
        end else if (wr_en) begin
            unique case (idx)
                REG_FRAMES_IN_USE: cfg_reg.frames_in_use       <= pwdata[COUNT_W-1:0];
                REG_START_RED:     cfg_reg.start_col[CH_RED]   <= pwdata[PIX_W-1:0];
                REG_START_GREEN:   cfg_reg.start_col[CH_GREEN] <= pwdata[PIX_W-1:0];
                REG_START_BLUE:    cfg_reg.start_col[CH_BLUE]  <= pwdata[PIX_W-1:0];
                REG_END_RED:       cfg_reg.end_col[CH_RED]     <= pwdata[PIX_W-1:0];
                REG_END_GREEN:     cfg_reg.end_col[CH_GREEN]   <= pwdata[PIX_W-1:0];
                REG_END_BLUE:      cfg_reg.end_col[CH_BLUE]    <= pwdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_FRAMES_IN_USE: prdata = DATA_W'(cfg_reg.frames_in_use);
            REG_START_RED:     prdata = DATA_W'(cfg_reg.start_col[CH_RED]);
            REG_START_GREEN:   prdata = DATA_W'(cfg_reg.start_col[CH_GREEN]);
            REG_START_BLUE:    prdata = DATA_W'(cfg_reg.start_col[CH_BLUE]);
            REG_END_RED:       prdata = DATA_W'(cfg_reg.end_col[CH_RED]);
            REG_END_GREEN:     prdata = DATA_W'(cfg_reg.end_col[CH_GREEN]);
            REG_END_BLUE:      prdata = DATA_W'(cfg_reg.end_col[CH_BLUE]);
            default:           prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/temporal_argmax_color_coder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// temporal_argmax_color_coder_unit
// Temporal maximum projection with color coding: finds the peak sample of a
// pixel over the frames in use and its earliest frame, and colors the peak.
// ----------------------------------------------------------------------------
//  channel   ports        direction  transfer when
//  samples   s_*          in         s_valid & s_ready
//  color     m_*          out        m_valid & m_ready
//  config    p* (APB)     in/out     psel & penable & pwrite (pready tied high)
//
//  One pixel per cycle sustained while m_ready is high.
//  The seven stages are the lane register, the three compare levels of the
//  merge tree and the three blend stages (numerator, reciprocal, scale).
//  Each stage holds its item only while the next one is full and stalled, so
//  input transfers continue into bubbles while a result waits on m_ready.
//  Reset is synchronous, active low; it empties the pipeline and loads the
//  register defaults.
// ----------------------------------------------------------------------------
module temporal_argmax_color_coder_unit
    import tacc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_sample_0,
    input  wire logic [7:0]        s_sample_1,
    input  wire logic [7:0]        s_sample_2,
    input  wire logic [7:0]        s_sample_3,
    input  wire logic [7:0]        s_sample_4,
    input  wire logic [7:0]        s_sample_5,
    input  wire logic [7:0]        s_sample_6,
    input  wire logic [7:0]        s_sample_7,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [7:0]             m_red_out,
    output logic [7:0]             m_green_out,
    output logic [7:0]             m_blue_out,
    output logic [7:0]             m_peak_value,
    output logic [2:0]             m_peak_frame,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    cfg_t                          cfg;
    logic [COUNT_W-1:0]            frames;
    logic [FRAME_W-1:0]            span;
    logic [NUM_STAGES-1:0]         vld_reg, vld_next;
    logic [NUM_STAGES-1:0]         adv;
    pixel_t [NUM_SAMPLES-1:0]      sample_vec;
    pixel_t [NUM_SAMPLES-1:0]      lane_val;
    merge_en_t                     merge_en;
    blend_en_t                     blend_en;
    pixel_t                        peak_l3;
    logic [FRAME_W-1:0]            where_l3;
    pixel_t                        peak_num_reg, peak_quot_reg, peak_out_reg;
    logic [FRAME_W-1:0]            where_num_reg, where_quot_reg, where_out_reg;
    pixel_t [NUM_CHANNELS-1:0]     chan_out;

    tacc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign frames = frame_count(cfg.frames_in_use);
    assign span   = FRAME_W'(frames - COUNT_W'(1));

    always_comb begin
        adv[STG_OUT] = ~vld_reg[STG_OUT] | m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            adv[k] = ~vld_reg[k] | adv[k+1];
        end
        vld_next[STG_LANE] = adv[STG_LANE] ? s_valid : vld_reg[STG_LANE];
        for (int k = 1; k < NUM_STAGES; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = adv[STG_LANE];
    assign m_valid = vld_reg[STG_OUT];

    assign sample_vec[0] = s_sample_0;
    assign sample_vec[1] = s_sample_1;
    assign sample_vec[2] = s_sample_2;
    assign sample_vec[3] = s_sample_3;
    assign sample_vec[4] = s_sample_4;
    assign sample_vec[5] = s_sample_5;
    assign sample_vec[6] = s_sample_6;
    assign sample_vec[7] = s_sample_7;

    for (genvar g = 0; g < NUM_SAMPLES; g++) begin : g_lane
        tacc_lane u_lane (
            .aclk         (aclk),
            .en           (adv[STG_LANE]),
            .lane_idx     (FRAME_W'(g)),
            .frames       (frames),
            .sample       (sample_vec[g]),
            .lane_val_reg (lane_val[g])
        );
    end

    assign merge_en.level1 = adv[STG_LEVEL1];
    assign merge_en.level2 = adv[STG_LEVEL2];
    assign merge_en.level3 = adv[STG_LEVEL3];

    tacc_merge u_merge (
        .aclk      (aclk),
        .en        (merge_en),
        .lane_val  (lane_val),
        .peak_reg  (peak_l3),
        .where_reg (where_l3)
    );

    assign blend_en.num   = adv[STG_NUM];
    assign blend_en.quot  = adv[STG_QUOT];
    assign blend_en.scale = adv[STG_OUT];

    for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
        tacc_blend u_blend (
            .aclk      (aclk),
            .en        (blend_en),
            .span      (span),
            .frame     (where_l3),
            .start_val (cfg.start_col[c]),
            .end_val   (cfg.end_col[c]),
            .peak      (peak_quot_reg),
            .chan_reg  (chan_out[c])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv[STG_NUM]) begin
            peak_num_reg  <= peak_l3;
            where_num_reg <= where_l3;
        end
        if (adv[STG_QUOT]) begin
            peak_quot_reg  <= peak_num_reg;
            where_quot_reg <= where_num_reg;
        end
        if (adv[STG_OUT]) begin
            peak_out_reg  <= peak_quot_reg;
            where_out_reg <= where_quot_reg;
        end
    end

    assign m_red_out    = chan_out[CH_RED];
    assign m_green_out  = chan_out[CH_GREEN];
    assign m_blue_out   = chan_out[CH_BLUE];
    assign m_peak_value = peak_out_reg;
    assign m_peak_frame = where_out_reg;

    a_frame_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (COUNT_W'(m_peak_frame) < frames))
        else $error("peak frame beyond frames in use");

    a_color_below_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_red_out <= m_peak_value && m_green_out <= m_peak_value
                     && m_blue_out <= m_peak_value))
        else $error("color channel exceeds peak value");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with output stage empty");

    a_occupancy_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(s_valid && s_ready) && !$past(m_valid && m_ready))
        |-> ($countones(vld_reg) == $past($countones(vld_reg)) + 1))
        else $error("transfer lost or duplicated in pipeline");

endmodule
`default_nettype wire
